### sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### sv/lzwc_pkg.sv
// Constants for the LZW byte compressor.
package lzwc_pkg;

    localparam int CODE_WIDTH_DEF = 12;    // bits per emitted code
    localparam int MAX_CODES_DEF  = 4096;  // dictionary size, power of two
    localparam int BYTE_W         = 8;
    localparam int LITERAL_CODES  = 256;   // codes 0..255 are the bytes themselves
    localparam int QUEUE_DEPTH    = 4;     // code requests between lookup and packer

endpackage

### sv/lzw_byte_compressor.sv
// LZW byte compressor: dictionary lookup pipeline and LSB-first code packer.
// Usage
//   Slave side takes one message byte per request (tdata = data_byte, tlast =
//   last_byte). Master side delivers the packed code stream, one byte per
//   request (tdata = packed_byte, tlast = stream_end on the final byte).
//   Codes are CODE_WIDTH bits, packed LSB-first; the message tail is padded
//   with zeros to a whole byte.
// Throughput
//   A byte launches once the last has left c1: the dictionary read, and the
//   check read whose address is the dictionary output, lie on the loop
//   through the current code. An item makes 0 to 4 output bytes at 12-bit
//   codes; the packer sends one per cycle while the master is ready and
//   throttles the input through its code queue.
// Path: an item's first output byte passes the input register, c1, c2,
//   the code queue, the packer accumulator and the output register.
// Reset and messages
//   Reset clears all control state; no memory sweep is needed. An entry
//   counts only when its code is below the free-code counter and the reverse
//   table confirms its address, so resetting the counter empties the table.
// Stall: a stalled master holds its byte; the queue fills and tready drops.
`include "assert_macros.svh"

module lzw_byte_compressor #(
    parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH_DEF,
    parameter int MAX_CODES  = lzwc_pkg::MAX_CODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input bytes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // last_byte
    // packed stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] packed_byte
    output logic       o_m_axis_tlast    // stream_end
);

    localparam int MAW    = $clog2(MAX_CODES);           // dictionary code bits
    localparam int TAW    = MAW + lzwc_pkg::BYTE_W;      // extension table address
    localparam int TDEPTH = MAX_CODES * lzwc_pkg::LITERAL_CODES;
    localparam int NFW    = MAW + 1;                     // free-code counter
    localparam int ACC_W  = lzwc_pkg::BYTE_W - 1 + 2 * CODE_WIDTH;
    localparam int CNTW   = $clog2(ACC_W + 1);
    localparam int QAW    = $clog2(lzwc_pkg::QUEUE_DEPTH);
    localparam int QCW    = QAW + 1;

    // ---------------------------------------------------------------
    // Input skid register
    // ---------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // ---------------------------------------------------------------
    // Dictionary state and lookup pipeline
    //   c0: extension table read at {current code, byte}
    //   c1: reverse table read at the code found (with write forwarding)
    //   c2: hit check, table update, code request to the packer
    // ---------------------------------------------------------------
    logic [MAW-1:0] r_cur;
    logic           r_have;
    logic [NFW-1:0] r_nf;
    logic [MAW-1:0] n_cur;
    logic           n_have;
    logic [NFW-1:0] n_nf;

    logic           r_s1_valid;
    logic [TAW-1:0] r_s1_idx;
    logic           r_s1_last;
    logic           r_s1_first;
    logic           r_s2_valid;
    logic [TAW-1:0] r_s2_idx;
    logic           r_s2_last;
    logic           r_s2_first;
    logic [MAW-1:0] r_s2_v;

    // contents need no clearing: stale entries fail the hit check
    bit   [MAW-1:0] r_ext_mem [TDEPTH];
    logic [MAW-1:0] r_ext_q;
    bit   [TAW-1:0] r_back_mem [MAX_CODES];
    logic [TAW-1:0] r_back_q;
    logic           r_fwd;
    logic [MAW-1:0] r_fwd_data;

    logic [TAW-1:0] ext_ra;
    logic           ext_we;
    logic [MAW-1:0] v_c1;
    logic           launch;

    // code queue
    logic [CODE_WIDTH-1:0] r_q_a    [lzwc_pkg::QUEUE_DEPTH];
    logic [CODE_WIDTH-1:0] r_q_b    [lzwc_pkg::QUEUE_DEPTH];
    logic                  r_q_two  [lzwc_pkg::QUEUE_DEPTH];
    logic                  r_q_fin  [lzwc_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]        r_q_wp;
    logic [QAW-1:0]        r_q_rp;
    logic [QCW-1:0]        r_q_cnt;
    logic                  q_push;
    logic                  q_pop;

    // c2 decision
    logic           hit;
    logic           miss;
    logic           room;
    logic [MAW-1:0] byte_code;
    logic [MAW-1:0] new_cur;
    logic [MAW-1:0] req_a;
    logic           req_two;

    assign byte_code = MAW'(r_s2_idx[lzwc_pkg::BYTE_W-1:0]);
    assign hit  = !r_s2_first
               && (r_s2_v >= MAW'(lzwc_pkg::LITERAL_CODES))
               && ({1'b0, r_s2_v} < r_nf)
               && (r_back_q == r_s2_idx);
    assign miss    = !r_s2_first && !hit;
    assign room    = r_nf < NFW'(MAX_CODES);
    assign new_cur = hit ? r_s2_v : byte_code;
    assign req_a   = miss ? r_cur : new_cur;
    assign req_two = miss && r_s2_last;
    assign ext_we  = r_s2_valid && miss && room;
    assign q_push  = r_s2_valid && (miss || r_s2_last);

    always_comb begin
        n_cur  = r_cur;
        n_have = r_have;
        n_nf   = r_nf;
        if (r_s2_valid) begin
            if (r_s2_last) begin
                n_cur  = '0;
                n_have = 1'b0;
                n_nf   = NFW'(lzwc_pkg::LITERAL_CODES);
            end else begin
                n_cur  = new_cur;
                n_have = 1'b1;
                if (ext_we) begin
                    n_nf = r_nf + 1'b1;
                end
            end
        end
    end

    // one item in the loop at a time; queue must hold every pending request
    assign launch = r_in_valid && !r_s1_valid
                 && ((r_q_cnt + QCW'(r_s2_valid)) < QCW'(lzwc_pkg::QUEUE_DEPTH));
    assign o_s_axis_tready = !r_in_valid || launch;
    assign ext_ra = {n_cur, r_in_byte};
    assign v_c1   = r_fwd ? r_fwd_data : r_ext_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_have     <= 1'b0;
            r_nf       <= NFW'(lzwc_pkg::LITERAL_CODES);
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_cur      <= n_cur;
            r_have     <= n_have;
            r_nf       <= n_nf;
            r_s1_valid <= launch;
            r_s2_valid <= r_s1_valid;
        end
        if (launch) begin
            r_s1_idx   <= ext_ra;
            r_s1_last  <= r_in_last;
            r_s1_first <= !n_have;
        end
        if (r_s1_valid) begin
            r_s2_idx   <= r_s1_idx;
            r_s2_last  <= r_s1_last;
            r_s2_first <= r_s1_first;
            r_s2_v     <= v_c1;
        end
    end

    // extension table: read-first, same-cycle collision forwarded
    always_ff @(posedge i_clk) begin
        r_ext_q <= r_ext_mem[ext_ra];
        if (ext_we) begin
            r_ext_mem[r_s2_idx] <= r_nf[MAW-1:0];
        end
        r_fwd      <= ext_we && (r_s2_idx == ext_ra);
        r_fwd_data <= r_nf[MAW-1:0];
    end

    // reverse table: code -> address it was added at
    always_ff @(posedge i_clk) begin
        r_back_q <= r_back_mem[v_c1];
        if (ext_we) begin
            r_back_mem[r_nf[MAW-1:0]] <= r_s2_idx;
        end
    end

    // ---------------------------------------------------------------
    // Code queue
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wp <= r_q_wp + 1'b1;
            end
            if (q_pop) begin
                r_q_rp <= r_q_rp + 1'b1;
            end
            r_q_cnt <= r_q_cnt + QCW'(q_push) - QCW'(q_pop);
        end
        if (q_push) begin
            r_q_a[r_q_wp]   <= CODE_WIDTH'(req_a);
            r_q_b[r_q_wp]   <= CODE_WIDTH'(byte_code);
            r_q_two[r_q_wp] <= req_two;
            r_q_fin[r_q_wp] <= r_s2_last;
        end
    end

    // ---------------------------------------------------------------
    // Bit packer and output register
    // ---------------------------------------------------------------
    logic [ACC_W-1:0] r_acc;
    logic [CNTW-1:0]  r_cnt;
    logic             r_pend;   // flush of message tail pending
    logic             r_ov;
    logic [7:0]       r_ob;
    logic             r_oe;

    logic             has_work;
    logic             out_free;
    logic             emit;
    logic             emit_end;
    logic [ACC_W-1:0] load_bits;
    logic [CNTW-1:0]  load_len;

    assign has_work = r_pend ? (r_cnt != '0) : (r_cnt >= CNTW'(lzwc_pkg::BYTE_W));
    assign out_free = !r_ov || i_m_axis_tready;
    assign emit     = has_work && out_free;
    assign emit_end = r_pend && (r_cnt <= CNTW'(lzwc_pkg::BYTE_W));
    assign q_pop    = !has_work && (r_q_cnt != '0);

    always_comb begin
        load_bits = ACC_W'(r_q_a[r_q_rp]) << r_cnt;
        load_len  = CNTW'(CODE_WIDTH);
        if (r_q_two[r_q_rp]) begin
            load_bits = load_bits
                      | (ACC_W'(r_q_b[r_q_rp]) << (r_cnt + CNTW'(CODE_WIDTH)));
            load_len  = CNTW'(2 * CODE_WIDTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (emit) begin
            r_acc <= r_acc >> lzwc_pkg::BYTE_W;
            r_cnt <= (r_cnt >= CNTW'(lzwc_pkg::BYTE_W))
                   ? r_cnt - CNTW'(lzwc_pkg::BYTE_W) : '0;
            if (emit_end) begin
                r_pend <= 1'b0;
            end
        end else if (q_pop) begin
            r_acc  <= r_acc | load_bits;
            r_cnt  <= r_cnt + load_len;
            r_pend <= r_q_fin[r_q_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
        if (emit) begin
            r_ob <= r_acc[7:0];
            r_oe <= emit_end;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_ob;
    assign o_m_axis_tlast  = r_oe;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_ALWAYS(a_one_in_loop, i_clk, i_rst_n, !(r_s1_valid && r_s2_valid), "two items in lookup loop")
    `ASSERT_IMPLIES(a_queue_room, i_clk, i_rst_n, q_push, (r_q_cnt < QCW'(lzwc_pkg::QUEUE_DEPTH)) || q_pop, "code queue overflow")
    `ASSERT_IMPLIES(a_load_space, i_clk, i_rst_n, q_pop, r_cnt < CNTW'(lzwc_pkg::BYTE_W), "packer loaded with full byte pending")
    `ASSERT_ALWAYS(a_nf_range, i_clk, i_rst_n, (r_nf >= NFW'(lzwc_pkg::LITERAL_CODES)) && (r_nf <= NFW'(MAX_CODES)), "free code out of range")

endmodule
